### sv/srsw_pkg.sv
// shared constants and types for the selective-repeat sender window
package srsw_pkg;

    localparam int SEQ_COUNT_DEF = 32;

    localparam int ACTION_W   = 2;
    localparam int SEQ_FIELD_W = 5;
    localparam int WIN_W      = 5;
    localparam int TIMEOUT_W  = 8;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_W-1:0]     WINDOW_SIZE_RST   = 5'd5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 8'd20;
    localparam logic [TOTAL_W-1:0]   TOTAL_PACKETS_RST = 16'd0;
    localparam logic [TIMEOUT_W-1:0] TIMER_MAX         = 8'hff;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

    // per-cycle commands from the sequencer to every slot cell
    typedef struct packed {
        logic grant;     // addressed slot goes out: unacked, timer started
        logic ack;       // addressed slot acknowledged: timer stopped
        logic tick;      // every running timer counts up
        logic retx_clr;  // cell holding the token restarts its timer
        logic load;      // token placed at the addressed slot
        logic advance;   // token moves one cell along the ring
    } cell_ctrl_t;

endpackage

### sv/srsw_cell.sv
// one sequence slot: acked bit, timer and scan token
module srsw_cell #(
    parameter int SEQ_W = 5,
    parameter int IDX   = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srsw_pkg::cell_ctrl_t            ctrl,
    input  logic [SEQ_W-1:0]                slot,
    input  logic [srsw_pkg::TIMEOUT_W-1:0]  timeout,
    input  logic                            token_in,
    output logic                            acked,
    output logic                            expired,
    output logic                            token_out
);

    logic                           acked_reg, acked_next;
    logic                           running_reg, running_next;
    logic [srsw_pkg::TIMEOUT_W-1:0] count_reg, count_next;
    logic                           token_reg, token_next;
    logic                           sel;

    assign sel = (slot == SEQ_W'(IDX));

    always_comb
    begin
        acked_next   = acked_reg;
        running_next = running_reg;
        count_next   = count_reg;
        token_next   = token_reg;
        if (ctrl.grant && sel)
        begin
            acked_next   = 1'b0;
            running_next = 1'b1;
            count_next   = '0;
        end
        else if (ctrl.ack && sel)
        begin
            acked_next   = 1'b1;
            running_next = 1'b0;
            count_next   = '0;
        end
        else if (ctrl.retx_clr && token_reg)
        begin
            count_next = '0;
        end
        else if (ctrl.tick && running_reg && (count_reg != srsw_pkg::TIMER_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
        if (ctrl.load)
        begin
            token_next = sel;
        end
        else if (ctrl.advance)
        begin
            token_next = token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg   <= 1'b1;
            running_reg <= 1'b0;
            count_reg   <= '0;
            token_reg   <= 1'b0;
        end
        else
        begin
            acked_reg   <= acked_next;
            running_reg <= running_next;
            count_reg   <= count_next;
            token_reg   <= token_next;
        end
    end

    assign acked     = acked_reg;
    assign expired   = running_reg && (count_reg >= timeout);
    assign token_out = token_reg;

endmodule

### sv/selective_repeat_sender_window.sv
// selective-repeat sender window: slot cell ring with scan sequencer
//
// usage: one transfer on the input channel (in_valid/in_ready) carries an
// action (send request, acknowledgment or timer tick) and an ack sequence.
// each accepted item gives exactly one result on the output channel
// (out_valid/out_ready): grant and sequence, retransmit slot, window base
// and the all-done flag. configuration (window size, timeout, total
// packets) is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while idle, which the block does not check. a send request, an ack
// that does not move the base, an ack that empties the window and the unused
// action go straight to the held result. an ack at the base walks a token
// along the cell ring, one slot a cycle, until it meets an unacked slot. a
// tick counts all running timers in the transfer cycle, then scans from slot
// 0, one slot a cycle, up to the first expired timer or the last slot. one
// item is worked on at a time. in_ready is high whenever the sequencer is
// idle; a finished result waits in a holding stage while the output register
// is full, so a stalled receiver holds the next result and then blocks new
// transfers. reset: every slot acked, timers stopped, base and next
// sequence 0, window size 5, timeout 20 ticks, total packets 0.
module selective_repeat_sender_window #(
    parameter int SEQ_COUNT = srsw_pkg::SEQ_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [srsw_pkg::ACTION_W-1:0]     action,
    input  logic [srsw_pkg::SEQ_FIELD_W-1:0]  ack_seq,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              granted,
    output logic [srsw_pkg::SEQ_FIELD_W-1:0]  sent_seq,
    output logic                              retransmit,
    output logic [srsw_pkg::SEQ_FIELD_W-1:0]  retransmit_seq,
    output logic [srsw_pkg::SEQ_FIELD_W-1:0]  window_base,
    output logic                              all_done
);

    localparam int SEQ_W = $clog2(SEQ_COUNT);
    localparam int CNT_W = $clog2(SEQ_COUNT + 1);
    // compare width: holds SEQ_COUNT, a distance and the 5-bit fields
    localparam int CMP_W = ((SEQ_W + 1) > srsw_pkg::SEQ_FIELD_W) ?
                           (SEQ_W + 1) : srsw_pkg::SEQ_FIELD_W;
    localparam logic [SEQ_W-1:0] LAST_SEQ = SEQ_W'(SEQ_COUNT - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;  // base walk after an ack at the base
    localparam logic [1:0] S_SCAN = 2'd2;  // expired-timer search after a tick
    localparam logic [1:0] S_DONE = 2'd3;  // result ready for the output register

    // configuration registers
    logic [srsw_pkg::WIN_W-1:0]     win_reg;
    logic [srsw_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [srsw_pkg::TOTAL_W-1:0]   total_reg;

    // window state
    logic [1:0]                   state_reg, state_next;
    logic [SEQ_W-1:0]             base_reg, base_next;
    logic [SEQ_W-1:0]             next_seq_reg, next_seq_next;
    logic [srsw_pkg::TOTAL_W-1:0] sent_cnt_reg, sent_cnt_next;
    logic [CNT_W-1:0]             unacked_reg, unacked_next;
    logic [SEQ_W-1:0]             scan_reg, scan_next;

    // held result of the item at work
    logic                            pend_granted_reg, pend_granted_next;
    logic [srsw_pkg::SEQ_FIELD_W-1:0] pend_sent_reg, pend_sent_next;
    logic                            pend_retx_reg, pend_retx_next;
    logic [srsw_pkg::SEQ_FIELD_W-1:0] pend_retx_seq_reg, pend_retx_seq_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic                            out_load;
    logic                            out_granted_reg;
    logic [srsw_pkg::SEQ_FIELD_W-1:0] out_sent_reg;
    logic                            out_retx_reg;
    logic [srsw_pkg::SEQ_FIELD_W-1:0] out_retx_seq_reg;
    logic [srsw_pkg::SEQ_FIELD_W-1:0] out_base_reg;
    logic                            out_done_reg;

    // cell ring
    srsw_pkg::cell_ctrl_t ctrl;
    logic [SEQ_W-1:0]     slot;
    logic [SEQ_COUNT-1:0] acked_vec;
    logic [SEQ_COUNT-1:0] expired_vec;
    logic [SEQ_COUNT-1:0] token_vec;

    // decoded input and helpers
    logic             accept;
    logic [CMP_W-1:0] ack_w;
    logic [CMP_W-1:0] seq_gap;
    logic             can_grant;
    logic             ack_ok;
    logic [SEQ_W-1:0] ack_slot;
    logic [CNT_W-1:0] unacked_after_ack;
    logic             walk_hit;
    logic             scan_hit;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // ring of slot cells, token handed from each cell to the next
    for (genvar i = 0; i < SEQ_COUNT; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? (SEQ_COUNT - 1) : (i - 1);
        srsw_cell #(
            .SEQ_W (SEQ_W),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .slot      (slot),
            .timeout   (timeout_reg),
            .token_in  (token_vec[PREV]),
            .acked     (acked_vec[i]),
            .expired   (expired_vec[i]),
            .token_out (token_vec[i])
        );
    end

    // distance of next sequence from the base, modulo the sequence count
    always_comb
    begin
        if (next_seq_reg >= base_reg)
        begin
            seq_gap = CMP_W'(next_seq_reg) - CMP_W'(base_reg);
        end
        else
        begin
            seq_gap = CMP_W'(next_seq_reg) + CMP_W'(SEQ_COUNT) - CMP_W'(base_reg);
        end
    end

    assign can_grant = acked_vec[next_seq_reg] && (seq_gap < CMP_W'(win_reg)) &&
                       (sent_cnt_reg < total_reg);
    assign ack_w     = CMP_W'(ack_seq);
    assign ack_ok    = (ack_w < CMP_W'(SEQ_COUNT));
    assign ack_slot  = SEQ_W'(ack_seq);
    assign unacked_after_ack = acked_vec[ack_slot] ? unacked_reg :
                               (unacked_reg - 1'b1);
    assign walk_hit  = |(token_vec & ~acked_vec);
    assign scan_hit  = |(token_vec & expired_vec);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        base_next          = base_reg;
        next_seq_next      = next_seq_reg;
        sent_cnt_next      = sent_cnt_reg;
        unacked_next       = unacked_reg;
        scan_next          = scan_reg;
        pend_granted_next  = pend_granted_reg;
        pend_sent_next     = pend_sent_reg;
        pend_retx_next     = pend_retx_reg;
        pend_retx_seq_next = pend_retx_seq_reg;
        ctrl               = '0;
        slot               = next_seq_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_granted_next  = 1'b0;
                    pend_sent_next     = '0;
                    pend_retx_next     = 1'b0;
                    pend_retx_seq_next = '0;
                    state_next         = S_DONE;
                    case (action)
                        srsw_pkg::ACT_SEND:
                        begin
                            if (can_grant)
                            begin
                                ctrl.grant        = 1'b1;
                                slot              = next_seq_reg;
                                pend_granted_next = 1'b1;
                                pend_sent_next    = srsw_pkg::SEQ_FIELD_W'(next_seq_reg);
                                next_seq_next     = (next_seq_reg == LAST_SEQ) ? '0 :
                                                    (next_seq_reg + 1'b1);
                                sent_cnt_next     = sent_cnt_reg + 1'b1;
                                unacked_next      = unacked_reg + 1'b1;
                            end
                        end
                        srsw_pkg::ACT_ACK:
                        begin
                            if (ack_ok)
                            begin
                                ctrl.ack     = 1'b1;
                                slot         = ack_slot;
                                unacked_next = unacked_after_ack;
                                if (ack_w == CMP_W'(base_reg))
                                begin
                                    if (unacked_after_ack == '0)
                                    begin
                                        // nothing outstanding: base jumps to next
                                        base_next = next_seq_reg;
                                    end
                                    else
                                    begin
                                        // token starts on the base, now acked
                                        ctrl.load  = 1'b1;
                                        scan_next  = base_reg;
                                        state_next = S_WALK;
                                    end
                                end
                            end
                        end
                        srsw_pkg::ACT_TICK:
                        begin
                            ctrl.tick  = 1'b1;
                            ctrl.load  = 1'b1;
                            slot       = '0;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            // unused action: report only
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_hit)
                begin
                    base_next  = scan_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    scan_next    = (scan_reg == LAST_SEQ) ? '0 : (scan_reg + 1'b1);
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    ctrl.retx_clr      = 1'b1;
                    pend_retx_next     = 1'b1;
                    pend_retx_seq_next = srsw_pkg::SEQ_FIELD_W'(scan_reg);
                    state_next         = S_DONE;
                end
                else if (scan_reg == LAST_SEQ)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= srsw_pkg::WINDOW_SIZE_RST;
            timeout_reg <= srsw_pkg::TIMEOUT_TICKS_RST;
            total_reg   <= srsw_pkg::TOTAL_PACKETS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srsw_pkg::REG_WINDOW_SIZE:   win_reg     <= cfg_data[srsw_pkg::WIN_W-1:0];
                srsw_pkg::REG_TIMEOUT_TICKS: timeout_reg <= cfg_data[srsw_pkg::TIMEOUT_W-1:0];
                srsw_pkg::REG_TOTAL_PACKETS: total_reg   <= cfg_data[srsw_pkg::TOTAL_W-1:0];
                default:
                begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            next_seq_reg  <= '0;
            sent_cnt_reg  <= '0;
            unacked_reg   <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            sent_cnt_reg  <= sent_cnt_next;
            unacked_reg   <= unacked_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        pend_granted_reg  <= pend_granted_next;
        pend_sent_reg     <= pend_sent_next;
        pend_retx_reg     <= pend_retx_next;
        pend_retx_seq_reg <= pend_retx_seq_next;
        if (out_load)
        begin
            out_granted_reg  <= pend_granted_reg;
            out_sent_reg     <= pend_sent_reg;
            out_retx_reg     <= pend_retx_reg;
            out_retx_seq_reg <= pend_retx_seq_reg;
            out_base_reg     <= srsw_pkg::SEQ_FIELD_W'(base_reg);
            out_done_reg     <= (sent_cnt_reg >= total_reg) && (unacked_reg == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = out_granted_reg;
    assign sent_seq       = out_sent_reg;
    assign retransmit     = out_retx_reg;
    assign retransmit_seq = out_retx_seq_reg;
    assign window_base    = out_base_reg;
    assign all_done       = out_done_reg;

endmodule
